### sv/psk_pea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psk_pea_pkg;

	// Modulation order selected by the mode register.
	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_BPSK = 2'd1,
		MODE_QPSK = 2'd2,
		MODE_8PSK = 2'd3
	} psk_mode_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_PSK_MODE     = 1'b0,
		REG_BLOCK_LENGTH = 1'b1
	} cfg_reg_t;

	localparam int SAMPLE_W  = 16;
	localparam int TERM_W    = 18;
	localparam int SUM_W     = 30;
	localparam int LEN_W     = 13;
	localparam int CFG_IDX_W = 1;

	// Scale factor for the dominant axis in 8PSK, applied as (v * K) >>> 16.
	localparam logic signed [SAMPLE_W-1:0] K_SCALE = 16'sd27146;
	localparam int K_SHIFT = 16;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [TERM_W-1:0]   term_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	// Handshake for the term channel between the front and the queue.
	typedef struct packed {
		logic  valid;
		term_t term;
	} term_xfer_t;

endpackage

`default_nettype wire

### sv/psk_pea_front.sv
`timescale 1ns / 1ps
`default_nettype none

module psk_pea_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire psk_pea_pkg::psk_mode_t mode,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire psk_pea_pkg::sample_t   sample_i,
	input  wire psk_pea_pkg::sample_t   sample_q,
	output psk_pea_pkg::term_xfer_t     push,
	input  wire logic                   push_ready
);

	localparam int SAMPLE_W_P = psk_pea_pkg::SAMPLE_W - 1;

	// Stage 1: registered sample and mode.
	logic                   valid_s1;
	psk_pea_pkg::sample_t   si_s1;
	psk_pea_pkg::sample_t   sq_s1;
	psk_pea_pkg::psk_mode_t mode_s1;

	// Stage 2: scaled dominant axis plus the raw sample.
	logic                   valid_s2;
	psk_pea_pkg::sample_t   si_s2;
	psk_pea_pkg::sample_t   sq_s2;
	psk_pea_pkg::psk_mode_t mode_s2;
	logic                   i_dom_s2;
	logic signed [31:0]     prod_s2;

	logic                               adv_s1;
	logic                               adv_s2;
	logic [psk_pea_pkg::SAMPLE_W:0]     abs_i;
	logic [psk_pea_pkg::SAMPLE_W:0]     abs_q;
	logic                               i_dom;
	psk_pea_pkg::sample_t               dom_sel;
	logic signed [31:0]                 prod;

	// Stage 2 empties when its term is transferred into the queue.
	assign adv_s2   = !valid_s2 || push_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Magnitude compare and the single scaling multiply.
	always_comb begin
		abs_i   = si_s1[SAMPLE_W_P] ? (17'd0 - {si_s1[SAMPLE_W_P], si_s1})
		                            : {si_s1[SAMPLE_W_P], si_s1};
		abs_q   = sq_s1[SAMPLE_W_P] ? (17'd0 - {sq_s1[SAMPLE_W_P], sq_s1})
		                            : {sq_s1[SAMPLE_W_P], sq_s1};
		i_dom   = abs_i >= abs_q;
		dom_sel = i_dom ? si_s1 : sq_s1;
		prod    = 32'(dom_sel) * 32'(psk_pea_pkg::K_SCALE);
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			si_s1   <= sample_i;
			sq_s1   <= sample_q;
			mode_s1 <= mode;
		end
		if (adv_s2 && valid_s1) begin
			si_s2    <= si_s1;
			sq_s2    <= sq_s1;
			mode_s2  <= mode_s1;
			i_dom_s2 <= i_dom;
			prod_s2  <= prod;
		end
	end

	// Error term: sgn(I)*x - sgn(Q)*y, with x and y picked by the mode.
	psk_pea_pkg::sample_t k_val;
	psk_pea_pkg::term_t   x_val;
	psk_pea_pkg::term_t   y_val;
	psk_pea_pkg::term_t   x_sgn;
	psk_pea_pkg::term_t   y_sgn;

	always_comb begin
		k_val = prod_s2[31:psk_pea_pkg::K_SHIFT];
		unique case (mode_s2)
			psk_pea_pkg::MODE_BPSK: begin
				x_val = 18'(sq_s2);
				y_val = '0;
			end
			psk_pea_pkg::MODE_QPSK: begin
				x_val = 18'(sq_s2);
				y_val = 18'(si_s2);
			end
			psk_pea_pkg::MODE_8PSK: begin
				x_val = i_dom_s2 ? 18'(sq_s2) : 18'(k_val);
				y_val = i_dom_s2 ? 18'(k_val) : 18'(si_s2);
			end
			default: begin
				x_val = '0;
				y_val = '0;
			end
		endcase
		x_sgn = si_s2[SAMPLE_W_P] ? -x_val : x_val;
		y_sgn = sq_s2[SAMPLE_W_P] ? -y_val : y_val;
		push.valid = valid_s2;
		push.term  = x_sgn - y_sgn;
	end

endmodule

`default_nettype wire

### sv/psk_pea_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module psk_pea_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire psk_pea_pkg::term_xfer_t push,
	output logic                        push_ready,
	output logic                        pop_valid,
	output psk_pea_pkg::term_t          pop_term,
	input  wire logic                   pop
);

	psk_pea_pkg::term_t mem_q [psk_pea_pkg::QUEUE_DEPTH];

	logic [psk_pea_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [psk_pea_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [psk_pea_pkg::QCNT_W-1:0] count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = count_q != psk_pea_pkg::QCNT_W'(psk_pea_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_term   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.term;
	end

endmodule

`default_nettype wire

### sv/psk_pea_back.sv
`timescale 1ns / 1ps
`default_nettype none

module psk_pea_back #(
	parameter int MAX_BLOCK = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [psk_pea_pkg::LEN_W-1:0]   block_length,
	input  wire logic                            pop_valid,
	input  wire psk_pea_pkg::term_t              pop_term,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output psk_pea_pkg::sum_t                    error_sum
);

	localparam int CW = $clog2(MAX_BLOCK + 1);
	localparam int LW = (CW > psk_pea_pkg::LEN_W) ? CW : psk_pea_pkg::LEN_W;

	logic [CW-1:0]     count_q;
	psk_pea_pkg::sum_t acc_q;
	psk_pea_pkg::sum_t sum_q;
	logic              out_valid_q;

	logic [LW-1:0]     len_ext;
	logic [LW-1:0]     len_eff;
	logic [LW:0]       count_next;
	logic              last;
	psk_pea_pkg::sum_t acc_next;

	// Block length clamped to the range 1..MAX_BLOCK.
	always_comb begin
		len_ext = LW'(block_length);
		if (len_ext == '0)
			len_eff = LW'(1);
		else if (len_ext > LW'(MAX_BLOCK))
			len_eff = LW'(MAX_BLOCK);
		else
			len_eff = len_ext;
		count_next = (LW + 1)'(count_q) + (LW + 1)'(1);
		last       = count_next >= (LW + 1)'(len_eff);
		acc_next   = acc_q + psk_pea_pkg::SUM_W'(pop_term);
	end

	// A closing term waits until the output register is free.
	assign pop       = pop_valid && (!last || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign error_sum = sum_q;

	// Running sum, sample count and output flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && last)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (pop) begin
				if (last) begin
					count_q <= '0;
					acc_q   <= '0;
				end else begin
					count_q <= count_next[CW-1:0];
					acc_q   <= acc_next;
				end
			end
		end
	end

	// Block result register.
	always_ff @(posedge clk) begin
		if (pop && last) sum_q <= acc_next;
	end

endmodule

`default_nettype wire

### sv/psk_phase_error_accumulator.sv
// M-PSK Costas phase error accumulator.
// Samples enter on in_valid/in_ready (sample_i, sample_q), one transfer per
// clock when the result side keeps up. Each sample yields a Costas error term
// for the configured modulation; terms are summed and, on the sample that
// closes a block of block_length samples, the sum leaves as one transfer on
// out_valid/out_ready (error_sum). Other samples produce no result.
// A closing sample passes the stage 1 and stage 2 registers and the queue
// before its sum is registered; the front pipeline is two registers
// (magnitude compare and the single scaling multiply, then term formation)
// feeding a four-entry queue, and the back part folds one term per cycle
// into the accumulator. Throughput: one sample per cycle, barring stalls.
// A stalled receiver holds the finished sum; the queue absorbs further
// samples until it fills, after which in_ready drops.
// Configuration writes on cfg_valid/cfg_ready (cfg_index, cfg_data) are
// always accepted; the user must make them while no samples are in flight.
// The block does not enforce it. Reset clears the pipeline, queue, running
// sum and count, and sets mode to BPSK and the block length to one sample.
`timescale 1ns / 1ps
`default_nettype none

module psk_phase_error_accumulator #(
	parameter int MAX_BLOCK = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [psk_pea_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psk_pea_pkg::LEN_W-1:0]       cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [15:0]                  sample_i,
	input  wire logic signed [15:0]                  sample_q,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [29:0]                       error_sum
);

	psk_pea_pkg::psk_mode_t         mode_q;
	logic [psk_pea_pkg::LEN_W-1:0]  block_length_q;
	psk_pea_pkg::term_xfer_t        push;
	logic                           push_ready;
	logic                           pop_valid;
	psk_pea_pkg::term_t             pop_term;
	logic                           pop;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= psk_pea_pkg::MODE_BPSK;
			block_length_q <= psk_pea_pkg::LEN_W'(1);
		end else if (cfg_valid) begin
			unique case (psk_pea_pkg::cfg_reg_t'(cfg_index))
				psk_pea_pkg::REG_PSK_MODE:
					mode_q <= psk_pea_pkg::psk_mode_t'(cfg_data[1:0]);
				psk_pea_pkg::REG_BLOCK_LENGTH:
					block_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front part: sample intake and error term computation.
	psk_pea_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_i   (sample_i),
		.sample_q   (sample_q),
		.push       (push),
		.push_ready (push_ready)
	);

	// Term queue between the two parts.
	psk_pea_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_term   (pop_term),
		.pop        (pop)
	);

	// Back part: block accumulation and result output.
	psk_pea_back #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.block_length (block_length_q),
		.pop_valid    (pop_valid),
		.pop_term     (pop_term),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.error_sum    (error_sum)
	);

endmodule

`default_nettype wire
